[rtl/rgr_pkg.sv]
// Package for the rational GCD reduce block: widths, codes, state type.
// No dependencies.
package rgr_pkg;
	localparam int WIDTH = 32;
	localparam int MAG_W = 64;
	localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (WIDTH - 1);

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZDEN = 2'd1,
		ST_OVF  = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL_N1, S_MUL_N2, S_MUL_D, S_CHECK,
		S_GCD, S_DIV_N, S_DIV_D, S_FIT, S_DONE
	} state_t;
endpackage

[rtl/rgr_if.sv]
// Channel interfaces: request and response with valid/ready handshake.
// No dependencies.
interface rgr_req_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  command;
	logic signed [31:0] a_num;
	logic signed [31:0] a_den;
	logic signed [31:0] b_num;
	logic signed [31:0] b_den;
	modport source (output valid, command, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, command, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rgr_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_num;
	logic signed [31:0] result_den;
	logic        [1:0]  status;
	modport source (output valid, result_num, result_den, status, input ready);
	modport sink (input valid, result_num, result_den, status, output ready);
endinterface

[rtl/rational_arith_gcd_reduce_core.sv]
// Rational arithmetic with GCD reduction: sequencer and sign/magnitude datapath.
// Depends on rgr_pkg, rgr_if, rgr_mul, rgr_gcd, rgr_div.
//
// Usage: a request item (command, a_num, a_den, b_num, b_den) enters on req
// when valid and ready are high; req.ready is high only while the core is idle.
// One response item (result_num, result_den, status) leaves on rsp per request.
// Each cross product runs on the bit-serial multiplier
// (three for add/subtract, two otherwise), then the binary GCD runs (one
// subtract or shift per cycle plus the power-of-two restore), then the two
// divisions run on the restoring divider. A zero-denominator item skips GCD
// and division. The core returns to idle after each item, with one item in
// flight at a time.
// The response is held in an output register; if rsp.ready is low the core
// finishes the next item and waits with it until the register is free.
// Reset (arst_n low) clears the sequencer and the response valid flag.
module rational_arith_gcd_reduce_core import rgr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rgr_req_if.sink   req,
	rgr_rsp_if.source rsp
);
	state_t state_q, state_d;
	logic   start_q;

	logic [1:0]       cmd_q;
	logic [31:0]      an_q, ad_q, bn_q, bd_q;
	logic             an_s_q, ad_s_q, bn_s_q, bd_s_q;
	logic [MAG_W-1:0] num_q, den_q, g_q;
	logic             num_s_q, den_s_q;
	logic [31:0]      rnum_q, rden_q;
	logic [1:0]       rst_q;
	logic [31:0]      onum_q, oden_q;
	logic [1:0]       ost_q;
	logic             ovalid_q;

	logic [31:0]      mul_a, mul_b;
	logic             mul_done, gcd_done, div_done;
	logic [MAG_W-1:0] prod, gval, quo, div_n;
	logic             p_s, p2_s;
	logic [MAG_W-1:0] sum_mag;
	logic             sum_s;
	logic             num_fit, den_fit, out_free, accept;

	assign accept   = req.valid && req.ready;
	assign out_free = !ovalid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= (state_d != state_q);
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid)
					state_d = S_MUL_N1;
			end
			S_MUL_N1: if (mul_done)
				state_d = (cmd_q == CMD_ADD || cmd_q == CMD_SUB) ? S_MUL_N2 : S_MUL_D;
			S_MUL_N2: if (mul_done) state_d = S_MUL_D;
			S_MUL_D:  if (mul_done) state_d = S_CHECK;
			S_CHECK:  state_d = (den_q == '0) ? S_DONE : S_GCD;
			S_GCD:    if (gcd_done) state_d = S_DIV_N;
			S_DIV_N:  if (div_done) state_d = S_DIV_D;
			S_DIV_D:  if (div_done) state_d = S_FIT;
			S_FIT:    state_d = S_DONE;
			S_DONE:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// operand selection per phase
	always_comb begin
		case (state_q)
			S_MUL_N1: begin
				mul_a = an_q;
				mul_b = (cmd_q == CMD_MUL) ? bn_q : bd_q;
				p_s   = an_s_q ^ ((cmd_q == CMD_MUL) ? bn_s_q : bd_s_q);
			end
			S_MUL_N2: begin
				mul_a = bn_q;
				mul_b = ad_q;
				p_s   = bn_s_q ^ (cmd_q == CMD_SUB) ^ ad_s_q;
			end
			default: begin
				mul_a = ad_q;
				mul_b = (cmd_q == CMD_DIV) ? bn_q : bd_q;
				p_s   = ad_s_q ^ ((cmd_q == CMD_DIV) ? bn_s_q : bd_s_q);
			end
		endcase
	end

	assign p2_s = (prod != '0) && p_s;

	// signed-magnitude add of num_q and the second product
	always_comb begin
		if (num_s_q == p2_s) begin
			sum_mag = num_q + prod;
			sum_s   = num_s_q;
		end else if (num_q >= prod) begin
			sum_mag = num_q - prod;
			sum_s   = num_s_q;
		end else begin
			sum_mag = prod - num_q;
			sum_s   = p2_s;
		end
		if (sum_mag == '0)
			sum_s = 1'b0;
	end

	assign num_fit = num_s_q ? (num_q <= LIM) : (num_q < LIM);
	assign den_fit = den_s_q ? (den_q <= LIM) : (den_q < LIM);
	assign div_n   = (state_q == S_DIV_N) ? num_q : den_q;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (accept) begin
				cmd_q  <= req.command;
				an_s_q <= req.a_num[31];
				ad_s_q <= req.a_den[31];
				bn_s_q <= req.b_num[31];
				bd_s_q <= req.b_den[31];
				an_q   <= req.a_num[31] ? 32'(-req.a_num) : 32'(req.a_num);
				ad_q   <= req.a_den[31] ? 32'(-req.a_den) : 32'(req.a_den);
				bn_q   <= req.b_num[31] ? 32'(-req.b_num) : 32'(req.b_num);
				bd_q   <= req.b_den[31] ? 32'(-req.b_den) : 32'(req.b_den);
			end
			S_MUL_N1: if (mul_done) begin
				num_q   <= prod;
				num_s_q <= p2_s;
			end
			S_MUL_N2: if (mul_done) begin
				num_q   <= sum_mag;
				num_s_q <= sum_s;
			end
			S_MUL_D: if (mul_done) begin
				den_q   <= prod;
				den_s_q <= p2_s;
			end
			S_CHECK: begin
				rnum_q <= '0;
				rden_q <= '0;
				rst_q  <= ST_ZDEN;
			end
			S_GCD: if (gcd_done) g_q <= gval;
			S_DIV_N: if (div_done) num_q <= quo;
			S_DIV_D: if (div_done) den_q <= quo;
			S_FIT: begin
				if (num_fit && den_fit) begin
					rnum_q <= num_s_q ? 32'(-num_q) : num_q[31:0];
					rden_q <= den_s_q ? 32'(-den_q) : den_q[31:0];
					rst_q  <= ST_OK;
				end else begin
					rnum_q <= '0;
					rden_q <= '0;
					rst_q  <= ST_OVF;
				end
			end
			default: ;
		endcase
		if (state_q == S_DONE && out_free) begin
			onum_q <= rnum_q;
			oden_q <= rden_q;
			ost_q  <= rst_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (state_q == S_DONE && out_free)
			ovalid_q <= 1'b1;
		else if (rsp.ready)
			ovalid_q <= 1'b0;
	end

	rgr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q && (state_q == S_MUL_N1 || state_q == S_MUL_N2 ||
		                     state_q == S_MUL_D)),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	rgr_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q && state_q == S_GCD),
		.x      (num_q),
		.y      (den_q),
		.done   (gcd_done),
		.g      (gval)
	);

	rgr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q && (state_q == S_DIV_N || state_q == S_DIV_D)),
		.dividend (div_n),
		.divisor  (g_q),
		.done     (div_done),
		.quo      (quo)
	);

	assign rsp.valid      = ovalid_q;
	assign rsp.result_num = onum_q;
	assign rsp.result_den = oden_q;
	assign rsp.status     = ost_q;
endmodule

[rtl/rgr_mul.sv]
// Bit-serial shift-add multiplier, 32x32 -> 64, one multiplier bit per cycle.
// Depends on rgr_pkg.
module rgr_mul import rgr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [31:0]      a,
	input  logic [31:0]      b,
	output logic             done,
	output logic [MAG_W-1:0] prod
);
	logic [MAG_W-1:0] mcand_q;
	logic [31:0]      mplier_q;
	logic [MAG_W-1:0] acc_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= MAG_W'(a);
			mplier_q <= b;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

[rtl/rgr_gcd.sv]
// Binary GCD on 64-bit magnitudes: one subtract or shift per cycle,
// then the common power of two is shifted back in one bit per cycle.
// Depends on rgr_pkg.
module rgr_gcd import rgr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] x,
	input  logic [MAG_W-1:0] y,
	output logic             done,
	output logic [MAG_W-1:0] g
);
	logic [MAG_W-1:0] u_q, v_q;
	logic [5:0]       k_q;
	logic             run_q, back_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			back_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				back_q <= 1'b0;
			end else if (run_q && u_q == '0) begin
				run_q  <= 1'b0;
				back_q <= 1'b1;
			end else if (back_q && k_q == '0) begin
				back_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			u_q <= x;
			v_q <= y;
			k_q <= '0;
		end else if (run_q && u_q != '0) begin
			if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 6'd1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= u_q - v_q;
			end else begin
				v_q <= v_q - u_q;
			end
		end else if (back_q && k_q != '0) begin
			v_q <= v_q << 1;
			k_q <= k_q - 6'd1;
		end
	end

	assign done = done_q;
	assign g    = v_q;
endmodule

[rtl/rgr_div.sv]
// Restoring divider, 64/64, one quotient bit per cycle.
// Depends on rgr_pkg.
module rgr_div import rgr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] dividend,
	input  logic [MAG_W-1:0] divisor,
	output logic             done,
	output logic [MAG_W-1:0] quo
);
	logic [MAG_W:0]   rem_q;
	logic [MAG_W-1:0] quo_q;
	logic [MAG_W-1:0] dvs_q;
	logic [6:0]       cnt_q;
	logic             busy_q, done_q;
	logic [MAG_W:0]   trial;

	assign trial = {rem_q[MAG_W-1:0], quo_q[MAG_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= trial - {1'b0, dvs_q};
				quo_q <= {quo_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

[rtl/rgr_checker.sv]
// Port-level checks for the rational GCD reduce core, bound to the top level.
// Depends on rgr_pkg and rational_arith_gcd_reduce_core.
module rgr_port_checks import rgr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] result_num,
	input logic [31:0] result_den,
	input logic [1:0]  status
);
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status != ST_RSVD)
		else $error("reserved status code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_ZDEN || status == ST_OVF) |->
		result_num == '0 && result_den == '0)
		else $error("error item with nonzero fields");

	a_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_OK |-> result_den != '0)
		else $error("ok item with zero denominator");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_num) &&
		$stable(result_den) && $stable(status))
		else $error("stalled item changed");
endmodule

bind rational_arith_gcd_reduce_core rgr_port_checks u_rgr_port_checks (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.result_num (rsp.result_num),
	.result_den (rsp.result_den),
	.status     (rsp.status)
);

[sim/rgr_checker.sv]
// Checker for the rational GCD reduce core: predicts each response item from
// the accepted request items and compares. Depends on rgr_pkg and rgr_if.
module rgr_checker import rgr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rgr_req_if.sink    req_mon,
	rgr_rsp_if.sink    rsp_mon,
	output int         errors,
	output int         pending,
	output int         rsp_count,
	output int         status_seen [3:0]
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [31:0] num;
		logic signed [31:0] den;
		status_t            status;
	} fraction_t;

	typedef struct {
		logic        neg;
		logic [63:0] mag;
	} signed_mag_t;

	fraction_t expected_q[$];

	function automatic signed_mag_t to_smag(logic [31:0] x);
		signed_mag_t r;
		r.neg = x[31];
		r.mag = r.neg ? {32'd0, -x} : {32'd0, x};
		if (r.mag == 0) r.neg = 1'b0;
		return r;
	endfunction

	function automatic signed_mag_t prod(signed_mag_t a, signed_mag_t b);
		signed_mag_t r;
		r.mag = a.mag * b.mag;
		r.neg = (r.mag != 0) && (a.neg != b.neg);
		return r;
	endfunction

	function automatic signed_mag_t sum(signed_mag_t a, signed_mag_t b);
		signed_mag_t r;
		if (a.neg == b.neg) begin
			r.mag = a.mag + b.mag;
			r.neg = a.neg;
		end else if (a.mag >= b.mag) begin
			r.mag = a.mag - b.mag;
			r.neg = a.neg;
		end else begin
			r.mag = b.mag - a.mag;
			r.neg = b.neg;
		end
		if (r.mag == 0) r.neg = 1'b0;
		return r;
	endfunction

	function automatic logic in_range(signed_mag_t v);
		logic [63:0] lim;
		lim = 64'd1 << (WIDTH - 1);
		return v.neg ? (v.mag <= lim) : (v.mag < lim);
	endfunction

	function automatic fraction_t reduce_op(cmd_t cmd, logic [31:0] an_r, logic [31:0] ad_r,
			logic [31:0] bn_r, logic [31:0] bd_r);
		signed_mag_t an, ad, bn, bd, num, den;
		logic [63:0] x, y, t;
		fraction_t f;
		an = to_smag(an_r);
		ad = to_smag(ad_r);
		bn = to_smag(bn_r);
		bd = to_smag(bd_r);
		f = '{num: '0, den: '0, status: ST_OK};
		case (cmd)
			CMD_ADD, CMD_SUB: begin
				if (cmd == CMD_SUB) bn.neg = (bn.mag != 0) && !bn.neg;
				num = sum(prod(an, bd), prod(bn, ad));
				den = prod(ad, bd);
			end
			CMD_MUL: begin
				num = prod(an, bn);
				den = prod(ad, bd);
			end
			default: begin
				num = prod(an, bd);
				den = prod(ad, bn);
			end
		endcase
		if (den.mag == 0) begin
			f.status = ST_ZDEN;
			return f;
		end
		x = num.mag;
		y = den.mag;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		num.mag = num.mag / x;
		den.mag = den.mag / x;
		if (!in_range(num) || !in_range(den)) begin
			f.status = ST_OVF;
			return f;
		end
		f.num = num.neg ? -num.mag[31:0] : num.mag[31:0];
		f.den = den.neg ? -den.mag[31:0] : den.mag[31:0];
		return f;
	endfunction

	initial begin
		errors = 0;
		rsp_count = 0;
		status_seen = '{default: 0};
	end

	assign pending = expected_q.size();

	always @(posedge clk) begin
		fraction_t got, want;
		if (arst_n && req_mon.valid && req_mon.ready)
			expected_q.push_back(reduce_op(cmd_t'(req_mon.command), req_mon.a_num,
				req_mon.a_den, req_mon.b_num, req_mon.b_den));
		if (arst_n && rsp_mon.valid && rsp_mon.ready) begin
			got = '{num: rsp_mon.result_num, den: rsp_mon.result_den,
				status: status_t'(rsp_mon.status)};
			rsp_count <= rsp_count + 1;
			if (expected_q.size() == 0) begin
				errors <= errors + 1;
				if (errors < 10) $display("unexpected item: %p", got);
			end else begin
				want = expected_q.pop_front();
				status_seen[got.status] <= status_seen[got.status] + 1;
				if (got !== want) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("mismatch: exp num %0d den %0d st %0d, got num %0d den %0d st %0d",
							want.num, want.den, want.status, got.num, got.den, got.status);
				end
			end
		end
	end
endmodule

[sim/tb.sv]
// Testbench top for rational_arith_gcd_reduce_core: drives request items,
// stalls responses, gives the verdict. Depends on rgr_pkg, rgr_if, rgr_checker.
module tb;
	import rgr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 1430;

	logic clk;
	logic arst_n;
	int   errors, pending, rsp_count;
	int   status_seen [3:0];
	logic quiet;
	logic hold_off;

	rgr_req_if req();
	rgr_rsp_if rsp();

	rational_arith_gcd_reduce_core u_top (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	rgr_checker u_chk (.clk(clk), .arst_n(arst_n), .req_mon(req), .rsp_mon(rsp),
		.errors(errors), .pending(pending), .rsp_count(rsp_count), .status_seen(status_seen));

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("[rational_arith_gcd_reduce_core] ERROR");
		$finish;
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($signed($urandom_range(0, 4)) - 2);
			3, 4: return $urandom();
			5: return $urandom() << $urandom_range(0, 28);
			default: return 32'($signed($urandom_range(0, 2000)) - 1000);
		endcase
	endfunction

	// ready depends only on registered state, so it is sampled before the edge
	task automatic send(cmd_t cmd, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd);
		while (!quiet && $urandom_range(0, 99) < 23) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid   <= 1'b1;
		req.command <= cmd;
		req.a_num   <= an;
		req.a_den   <= ad;
		req.b_num   <= bn;
		req.b_den   <= bd;
		@(negedge clk);
		while (!req.ready) @(negedge clk);
		@(posedge clk);
	endtask

	// response side: random stalls, one long hold-off, a stretch without stalls
	always @(posedge clk) begin
		if (!arst_n || hold_off) rsp.ready <= 1'b0;
		else rsp.ready <= quiet || ($urandom_range(0, 99) >= 23);
	end

	initial begin
		int n, wait_cycles;
		cmd_t cmd;
		arst_n = 1'b0;
		quiet = 1'b0;
		hold_off = 1'b1;
		req.valid = 1'b0;
		req.command = CMD_ADD;
		req.a_num = '0;
		req.a_den = '0;
		req.b_num = '0;
		req.b_den = '0;
		rsp.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// long receiver hold-off while items keep being offered
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_off <= 1'b0;
			end
			begin
				send(CMD_ADD, 1, 2, 1, 3);
				send(CMD_SUB, 1, 2, 1, 2);
				send(CMD_MUL, 0, 5, 7, -3);
			end
		join
		send(CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send(CMD_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
		send(CMD_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
		send(CMD_SUB, 32'h8000_0000, 1, 32'h7fff_ffff, 1);
		send(CMD_ADD, 1, 0, 1, 5);
		send(CMD_DIV, 3, 4, 0, 5);
		send(CMD_MUL, 3, 4, 5, 0);
		send(CMD_SUB, 0, -7, 0, 3);
		send(CMD_DIV, 6, -4, -9, 2);
		send(CMD_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		send(CMD_ADD, -1, -1, -1, -1);
		send(CMD_DIV, 32'hffff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000);
		send(CMD_MUL, 32'h8000_0000, -1, 1, 1);
		send(CMD_ADD, 0, 0, 0, 0);
		send(CMD_SUB, 12345, 32'h5555_5555, -54321, 32'haaaa_aaaa);
		for (n = 0; n < N_RANDOM; n++) begin
			if (n == 300) quiet = 1'b1;
			if (n == 500) quiet = 1'b0;
			cmd = cmd_t'($urandom_range(0, 3));
			send(cmd, pick_value(), pick_value(), pick_value(), pick_value());
		end
		req.valid <= 1'b0;
		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (600) @(posedge clk);
		$display("covered %0d responses: %0d ok, %0d zero denominator, %0d overflow",
			rsp_count, status_seen[ST_OK], status_seen[ST_ZDEN], status_seen[ST_OVF]);
		if (errors == 0 && pending == 0)
			$display("[rational_arith_gcd_reduce_core] OK");
		else
			$display("[rational_arith_gcd_reduce_core] ERROR");
		$finish;
	end
endmodule
